// File: rtl/ssmc_pkg.sv
// ----------------------------------------------------------------------------
// ssmc_pkg
// Shared widths and record types for the sorted stream merge and combine block.
// ----------------------------------------------------------------------------
package ssmc_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned ColorW = 64;

  // One input word: the heads of both streams with their present flags.
  typedef struct packed {
    logic [KeyW-1:0]   key_a;
    logic [ColorW-1:0] colors_a;
    logic              has_a;
    logic [KeyW-1:0]   key_b;
    logic [ColorW-1:0] colors_b;
    logic              has_b;
  } in_word_t;

  // Outcome of the head selection, handed to the pending-record stage.
  typedef struct packed {
    logic              any_head;
    logic              take_a;
    logic [KeyW-1:0]   key;
    logic [ColorW-1:0] colors;
  } pick_t;

  // One output word.
  typedef struct packed {
    logic              emit;
    logic [KeyW-1:0]   out_key;
    logic [ColorW-1:0] out_colors_a;
    logic [ColorW-1:0] out_colors_b;
    logic              out_last;
    logic              took_a;
    logic              took_b;
  } out_word_t;

endpackage

// File: rtl/ssmc_in_if.sv
// ----------------------------------------------------------------------------
// ssmc_in_if
// Valid/ready channel that carries the two stream heads.
// ----------------------------------------------------------------------------
interface ssmc_in_if
  import ssmc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KeyW-1:0]   key_a;
  logic [ColorW-1:0] colors_a;
  logic              has_a;
  logic [KeyW-1:0]   key_b;
  logic [ColorW-1:0] colors_b;
  logic              has_b;

  modport source (output valid, key_a, colors_a, has_a, key_b, colors_b, has_b,
                  input ready);
  modport sink   (input valid, key_a, colors_a, has_a, key_b, colors_b, has_b,
                  output ready);
endinterface

// File: rtl/ssmc_out_if.sv
// ----------------------------------------------------------------------------
// ssmc_out_if
// Valid/ready channel that carries one merged result word.
// ----------------------------------------------------------------------------
interface ssmc_out_if
  import ssmc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              emit;
  logic [KeyW-1:0]   out_key;
  logic [ColorW-1:0] out_colors_a;
  logic [ColorW-1:0] out_colors_b;
  logic              out_last;
  logic              took_a;
  logic              took_b;

  modport source (output valid, emit, out_key, out_colors_a, out_colors_b, out_last,
                  took_a, took_b, input ready);
  modport sink   (input valid, emit, out_key, out_colors_a, out_colors_b, out_last,
                  took_a, took_b, output ready);
endinterface

// File: rtl/ssmc_select.sv
// ----------------------------------------------------------------------------
// ssmc_select
// Picks the head to consume: the smaller key, B on a tie, or the only one present.
// ----------------------------------------------------------------------------
module ssmc_select
  import ssmc_pkg::*;
(
  input  in_word_t word_i,
  output pick_t    pick_o
);

  logic take_a;

  always_comb begin
    if (word_i.has_a && word_i.has_b) begin
      take_a = word_i.key_a < word_i.key_b;
    end else begin
      take_a = word_i.has_a;
    end
  end

  assign pick_o.any_head = word_i.has_a | word_i.has_b;
  assign pick_o.take_a   = take_a;
  assign pick_o.key      = take_a ? word_i.key_a : word_i.key_b;
  assign pick_o.colors   = take_a ? word_i.colors_a : word_i.colors_b;

endmodule

// File: rtl/ssmc_pending.sv
// ----------------------------------------------------------------------------
// ssmc_pending
// Holds the pending merged record, combines equal keys and forms the result.
// ----------------------------------------------------------------------------
module ssmc_pending
  import ssmc_pkg::*;
#(
  parameter int unsigned COLOR_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  pick_t     pick_i,
  output out_word_t result_o
);

  logic                  pend_valid_q, pend_valid_d;
  logic [KeyW-1:0]       pend_key_q, pend_key_d;
  logic [COLOR_BITS-1:0] pend_ca_q, pend_ca_d;
  logic [COLOR_BITS-1:0] pend_cb_q, pend_cb_d;
  logic [COLOR_BITS-1:0] pick_colors;
  logic                  hit;

  // Bits above COLOR_BITS are dropped here and come back as zero on output.
  assign pick_colors = pick_i.colors[COLOR_BITS-1:0];
  assign hit         = pend_valid_q && (pend_key_q == pick_i.key);

  always_comb begin
    result_o     = '0;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    pend_ca_d    = pend_ca_q;
    pend_cb_d    = pend_cb_q;
    if (!pick_i.any_head) begin
      // Flush: the pending record, if any, closes the merged stream.
      if (pend_valid_q) begin
        result_o.emit         = 1'b1;
        result_o.out_key      = pend_key_q;
        result_o.out_colors_a = ColorW'(pend_ca_q);
        result_o.out_colors_b = ColorW'(pend_cb_q);
        result_o.out_last     = 1'b1;
      end
      pend_valid_d = 1'b0;
      pend_key_d   = '0;
      pend_ca_d    = '0;
      pend_cb_d    = '0;
    end else begin
      result_o.took_a = pick_i.take_a;
      result_o.took_b = ~pick_i.take_a;
      if (hit) begin
        if (pick_i.take_a) begin
          pend_ca_d = pick_colors;
        end else begin
          pend_cb_d = pick_colors;
        end
      end else begin
        if (pend_valid_q) begin
          result_o.emit         = 1'b1;
          result_o.out_key      = pend_key_q;
          result_o.out_colors_a = ColorW'(pend_ca_q);
          result_o.out_colors_b = ColorW'(pend_cb_q);
        end
        pend_valid_d = 1'b1;
        pend_key_d   = pick_i.key;
        pend_ca_d    = pick_i.take_a ? pick_colors : '0;
        pend_cb_d    = pick_i.take_a ? '0 : pick_colors;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_key_q   <= '0;
      pend_ca_q    <= '0;
      pend_cb_q    <= '0;
    end else if (advance_i) begin
      pend_valid_q <= pend_valid_d;
      pend_key_q   <= pend_key_d;
      pend_ca_q    <= pend_ca_d;
      pend_cb_q    <= pend_cb_d;
    end
  end

endmodule

// File: rtl/sorted_stream_merge_combine.sv
// ----------------------------------------------------------------------------
// sorted_stream_merge_combine
// Two-way merge of ascending key streams with combining of duplicate keys.
// ----------------------------------------------------------------------------
// Path: an accepted input word goes through the input register, then the output register.
// Throughput: one word per cycle while out_o.ready does not stall; the input register,
// one key compare and the pending-record update in front of the output register set it.
// Reset: asynchronous and active low; it empties both pipeline registers and
// clears the pending record, so the first word starts a new merged stream.
// ----------------------------------------------------------------------------
module sorted_stream_merge_combine
  import ssmc_pkg::*;
#(
  parameter int unsigned COLOR_BITS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  ssmc_in_if.sink    in_i,
  ssmc_out_if.source out_o
);

  // Input register. It holds one word of stream heads until the pending
  // stage can take it, which is whenever the output register is free or is
  // being emptied in the same cycle.
  logic      s1_valid_q;
  in_word_t  s1_q;
  logic      advance;

  // Output register. Every processed word produces exactly one result word,
  // including the words that only fold colors into the pending record.
  logic      out_valid_q;
  out_word_t out_q;

  pick_t     pick;
  out_word_t result;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.key_a    <= in_i.key_a;
      s1_q.colors_a <= in_i.colors_a;
      s1_q.has_a    <= in_i.has_a;
      s1_q.key_b    <= in_i.key_b;
      s1_q.colors_b <= in_i.colors_b;
      s1_q.has_b    <= in_i.has_b;
    end
  end

  // Choose which head is consumed this word.
  ssmc_select u_select (
    .word_i (s1_q),
    .pick_o (pick)
  );

  // Merge the chosen head into the pending record; the record only changes
  // when the word really moves on into the output register.
  ssmc_pending #(
    .COLOR_BITS (COLOR_BITS)
  ) u_pending (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .pick_i    (pick),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.emit         = out_q.emit;
  assign out_o.out_key      = out_q.out_key;
  assign out_o.out_colors_a = out_q.out_colors_a;
  assign out_o.out_colors_b = out_q.out_colors_b;
  assign out_o.out_last     = out_q.out_last;
  assign out_o.took_a       = out_q.took_a;
  assign out_o.took_b       = out_q.took_b;

endmodule
